FILE: design/ppeu_pkg.sv
// Shared types and constants for the packed pixel event unpacker.
package ppeu_pkg;

    localparam int PIX_PER_BYTE = 4;
    localparam int CODE_W       = 2;
    localparam int LANE_IDX_W   = $clog2(PIX_PER_BYTE);

    // Largest dimension a 12-bit register can hold, and the compare width.
    localparam int CFG_DIM_MAX = 4095;
    localparam int DIM_W       = 13;
    localparam int MAX_DIM_DEF = 2048;

    localparam int COORD_W = 11;
    localparam int TS_W    = 52;
    localparam int FNUM_W  = 32;
    localparam int IVL_W   = 20;
    localparam int CFG_W   = 12;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [IVL_W-1:0] IVL_RST    = 20'd1000;

    localparam logic [CODE_W-1:0] PIX_POS = 2'b01;
    localparam logic [CODE_W-1:0] PIX_NEG = 2'b10;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_INTERVAL     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [IVL_W-1:0] interval_us;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic               polarity;
    } t_event;

endpackage

FILE: design/ppeu_regs.sv
// Configuration register file behind the APB-style port.
module ppeu_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppeu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ppeu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ppeu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ppeu_pkg::t_cfg                    o_cfg
);
    import ppeu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= WIDTH_RST;
            r_cfg.frame_height <= HEIGHT_RST;
            r_cfg.interval_us  <= IVL_RST;
        end else if (wr_en) begin
            case (idx)
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[CFG_W-1:0];
                REG_INTERVAL:     r_cfg.interval_us  <= pwdata[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_cfg.frame_height);
            REG_INTERVAL:     prdata = APB_DATA_W'(r_cfg.interval_us);
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: design/ppeu_lane.sv
// One pixel lane: classifies a 2-bit code and advances the frame position.
module ppeu_lane #(
    parameter int MAX_DIM = ppeu_pkg::MAX_DIM_DEF,
    localparam int DIM_CAP = (MAX_DIM < ppeu_pkg::CFG_DIM_MAX) ? MAX_DIM
                                                                : ppeu_pkg::CFG_DIM_MAX,
    localparam int POS_W = $clog2(DIM_CAP)
) (
    input  logic [ppeu_pkg::CODE_W-1:0]  i_code,
    input  logic [ppeu_pkg::DIM_W-1:0]   i_width,
    input  logic [ppeu_pkg::DIM_W-1:0]   i_height,
    input  logic [POS_W-1:0]             i_col,
    input  logic [POS_W-1:0]             i_row,
    input  logic                         i_done,
    output logic                         o_hit,
    output ppeu_pkg::t_event             o_event,
    output logic [POS_W-1:0]             o_col,
    output logic [POS_W-1:0]             o_row,
    output logic                         o_done
);
    import ppeu_pkg::*;

    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    assign col_inc = DIM_W'(i_col) + 1'b1;
    assign row_inc = DIM_W'(i_row) + 1'b1;

    assign o_hit            = !i_done && (i_code == PIX_POS || i_code == PIX_NEG);
    assign o_event.x_pos    = COORD_W'(i_col);
    assign o_event.y_pos    = COORD_W'(i_row);
    assign o_event.polarity = (i_code == PIX_POS);

    // Once the frame is done the position stays where it is.
    always_comb begin
        o_col  = i_col;
        o_row  = i_row;
        o_done = i_done;
        if (!i_done) begin
            if (col_inc >= i_width) begin
                o_col = '0;
                if (row_inc >= i_height) begin
                    o_row  = '0;
                    o_done = 1'b1;
                end else begin
                    o_row = POS_W'(row_inc);
                end
            end else begin
                o_col = POS_W'(col_inc);
            end
        end
    end

endmodule

FILE: design/ppeu_merge.sv
// Merge stage: holds one word's lane events and sends them out one per cycle while the output is not stalled.
module ppeu_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ppeu_pkg::PIX_PER_BYTE-1:0]   i_hits,
    input  ppeu_pkg::t_event                    i_events [ppeu_pkg::PIX_PER_BYTE],
    input  logic [ppeu_pkg::TS_W-1:0]           i_timestamp,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ppeu_pkg::TS_W-1:0]           o_timestamp,
    output ppeu_pkg::t_event                    o_event,
    output logic                                o_last
);
    import ppeu_pkg::*;

    logic [PIX_PER_BYTE-1:0] r_pend, n_pend;
    t_event                  r_ev [PIX_PER_BYTE];
    logic [TS_W-1:0]         r_ts;
    logic                    r_out_valid;
    logic [TS_W-1:0]         r_out_ts;
    t_event                  r_out_ev;
    logic                    r_out_last;

    logic                    out_free;
    logic                    move;
    logic                    ready;
    logic                    load;
    logic [LANE_IDX_W-1:0]   sel;
    logic [PIX_PER_BYTE-1:0] rest;

    // Lowest pending lane goes first, which keeps pixel order.
    always_comb begin
        sel = '0;
        for (int k = PIX_PER_BYTE - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                sel = LANE_IDX_W'(k);
            end
        end
    end

    assign rest     = r_pend & ~(PIX_PER_BYTE'(1) << sel);
    assign out_free = !r_out_valid || !i_out_stall;
    assign move     = out_free && (r_pend != '0);
    assign ready    = (r_pend == '0) || (move && rest == '0);
    assign load     = i_valid && ready;
    assign o_stall  = !ready;

    always_comb begin
        if (load) begin
            n_pend = i_hits;
        end else if (move) begin
            n_pend = rest;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev <= i_events;
            r_ts <= i_timestamp;
        end
        if (move) begin
            r_out_ts   <= r_ts;
            r_out_ev   <= r_ev[sel];
            r_out_last <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_timestamp = r_out_ts;
    assign o_event     = r_out_ev;
    assign o_last      = r_out_last;

endmodule

FILE: design/packed_pixel_event_unpacker.sv
// Top level of the packed pixel event unpacker.
//
// Input words carry one packed byte of four 2-bit pixel codes (bits 7-6 first)
// with a frame-start flag and the frame number. A word is taken at a clock edge
// where i_in_valid is high and o_in_stall is low. Each event code (01 positive,
// 10 negative) yields one result word on the output channel with timestamp,
// column, row and polarity; o_last_of_byte marks the final event of a byte.
// Four lanes decode the pixels of a byte combinationally and advance the
// row-major position; a merge stage then sends the events out one per cycle
// while i_out_stall is low. The first event of a byte passes the merge
// stage's pending register and then its output register. A new byte is taken
// when no events are pending or as the last one moves to the single output
// register. Bytes without events or past the frame end give no result.
// When the receiver raises i_out_stall the output word holds, the merge stage
// fills up, and o_in_stall rises. Synchronous reset clears the position, the
// pending events and the output valid, and loads the register defaults
// (640 x 480 pixels, 1000 us interval). Registers sit at 0x0, 0x4 and 0x8.
module packed_pixel_event_unpacker #(
    parameter int MAX_DIM = ppeu_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppeu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ppeu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ppeu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_frame_start,
    input  logic [ppeu_pkg::FNUM_W-1:0]       i_frame_seq,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ppeu_pkg::TS_W-1:0]         o_timestamp,
    output logic [ppeu_pkg::COORD_W-1:0]      o_x_pos,
    output logic [ppeu_pkg::COORD_W-1:0]      o_y_pos,
    output logic                              o_polarity,
    output logic                              o_last_of_byte
);
    import ppeu_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < CFG_DIM_MAX) ? MAX_DIM : CFG_DIM_MAX;
    localparam int POS_W   = $clog2(DIM_CAP);

    t_cfg             cfg;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [TS_W-1:0]  ts;
    logic             accept;

    logic [POS_W-1:0] r_col, r_row;
    logic             r_done;

    logic [POS_W-1:0]        col_c  [PIX_PER_BYTE+1];
    logic [POS_W-1:0]        row_c  [PIX_PER_BYTE+1];
    logic [PIX_PER_BYTE:0]   done_c;
    logic [PIX_PER_BYTE-1:0] hits;
    t_event                  events [PIX_PER_BYTE];
    t_event                  out_ev;

    ppeu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign width_eff  = ({1'b0, cfg.frame_width} > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP)
                                                                   : {1'b0, cfg.frame_width};
    assign height_eff = ({1'b0, cfg.frame_height} > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP)
                                                                    : {1'b0, cfg.frame_height};

    assign ts = TS_W'(i_frame_seq) * TS_W'(cfg.interval_us);

    // A frame start clears the position; an empty geometry ends the frame at once.
    assign col_c[0]  = i_frame_start ? '0 : r_col;
    assign row_c[0]  = i_frame_start ? '0 : r_row;
    assign done_c[0] = (!i_frame_start && r_done) || width_eff == '0 || height_eff == '0;

    for (genvar k = 0; k < PIX_PER_BYTE; k++) begin : g_lane
        ppeu_lane #(
            .MAX_DIM (MAX_DIM)
        ) u_lane (
            .i_code   (i_data_byte[CODE_W*(PIX_PER_BYTE-1-k) +: CODE_W]),
            .i_width  (width_eff),
            .i_height (height_eff),
            .i_col    (col_c[k]),
            .i_row    (row_c[k]),
            .i_done   (done_c[k]),
            .o_hit    (hits[k]),
            .o_event  (events[k]),
            .o_col    (col_c[k+1]),
            .o_row    (row_c[k+1]),
            .o_done   (done_c[k+1])
        );
    end

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
        end else if (accept) begin
            r_col  <= col_c[PIX_PER_BYTE];
            r_row  <= row_c[PIX_PER_BYTE];
            r_done <= done_c[PIX_PER_BYTE];
        end
    end

    ppeu_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_hits      (hits),
        .i_events    (events),
        .i_timestamp (ts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_timestamp (o_timestamp),
        .o_event     (out_ev),
        .o_last      (o_last_of_byte)
    );

    assign o_x_pos    = out_ev.x_pos;
    assign o_y_pos    = out_ev.y_pos;
    assign o_polarity = out_ev.polarity;

endmodule

FILE: bench/pixel_event_checker.sv
// Checker that predicts the unpacker's event words and compares them as they leave.
module pixel_event_checker
    import ppeu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_frame_start,
    input  logic [FNUM_W-1:0]     i_frame_seq,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [TS_W-1:0]       i_timestamp,
    input  logic [COORD_W-1:0]    i_x_pos,
    input  logic [COORD_W-1:0]    i_y_pos,
    input  logic                  i_polarity,
    input  logic                  i_last_of_byte,
    output int                    o_fail_count,
    output int                    o_pending_count,
    output int                    o_checked_count
);

    typedef struct packed {
        logic [TS_W-1:0] timestamp;
        t_event          pix;
        logic            last_flag;
    } t_pix_word;

    localparam logic [CFG_W-1:0] DIM_CAP = CFG_W'(MAX_DIM_DEF);

    t_cfg               cfg;
    logic [COORD_W-1:0] pos_col;
    logic [COORD_W-1:0] pos_row;
    logic               past_frame_end;
    t_pix_word          expected_words[$];
    int                 fails   = 0;
    int                 pending = 0;
    int                 checked = 0;

    assign o_fail_count    = fails;
    assign o_pending_count = pending;
    assign o_checked_count = checked;

    // Decodes one packed byte into the event words it should produce and queues them.
    task automatic unpack_byte(input logic [7:0] pix_byte, input logic start,
                               input logic [FNUM_W-1:0] fseq);
        logic [CFG_W-1:0]  w;
        logic [CFG_W-1:0]  h;
        logic [TS_W-1:0]   ts;
        logic [CODE_W-1:0] code;
        t_pix_word         found[PIX_PER_BYTE];
        int                n;
        w  = (cfg.frame_width > DIM_CAP) ? DIM_CAP : cfg.frame_width;
        h  = (cfg.frame_height > DIM_CAP) ? DIM_CAP : cfg.frame_height;
        ts = TS_W'(fseq) * TS_W'(cfg.interval_us);
        n  = 0;
        if (start) begin
            pos_col        = '0;
            pos_row        = '0;
            past_frame_end = 1'b0;
        end
        if (w == '0 || h == '0) begin
            past_frame_end = 1'b1;
        end
        for (int k = 0; k < PIX_PER_BYTE; k++) begin
            code = pix_byte[7-2*k -: CODE_W];
            if (!past_frame_end) begin
                if (code == PIX_POS || code == PIX_NEG) begin
                    found[n].timestamp    = ts;
                    found[n].pix.x_pos    = pos_col;
                    found[n].pix.y_pos    = pos_row;
                    found[n].pix.polarity = (code == PIX_POS);
                    found[n].last_flag    = 1'b0;
                    n++;
                end
                // Every slot before the frame end moves the position, events or not;
                // the frame ends on the last slot of the last row.
                if (CFG_W'(pos_col) + 1'b1 >= w) begin
                    pos_col = '0;
                    if (CFG_W'(pos_row) + 1'b1 >= h) begin
                        pos_row        = '0;
                        past_frame_end = 1'b1;
                    end else begin
                        pos_row++;
                    end
                end else begin
                    pos_col++;
                end
            end
        end
        if (n > 0) begin
            found[n-1].last_flag = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_words.push_back(found[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_word want;
        t_pix_word got;
        if (!i_rst_n) begin
            cfg.frame_width  = WIDTH_RST;
            cfg.frame_height = HEIGHT_RST;
            cfg.interval_us  = IVL_RST;
            pos_col          = '0;
            pos_row          = '0;
            past_frame_end   = 1'b0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_FRAME_WIDTH:  cfg.frame_width  = pwdata[CFG_W-1:0];
                    REG_FRAME_HEIGHT: cfg.frame_height = pwdata[CFG_W-1:0];
                    REG_INTERVAL:     cfg.interval_us  = pwdata[IVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                unpack_byte(i_data_byte, i_frame_start, i_frame_seq);
            end
            if (i_out_valid && !i_out_stall) begin
                got.timestamp    = i_timestamp;
                got.pix.x_pos    = i_x_pos;
                got.pix.y_pos    = i_y_pos;
                got.pix.polarity = i_polarity;
                got.last_flag    = i_last_of_byte;
                if (expected_words.size() == 0) begin
                    if (fails < 10) begin
                        $display("Unexpected event word: ts=%0d x=%0d y=%0d pol=%0b last=%0b",
                                 got.timestamp, got.pix.x_pos, got.pix.y_pos,
                                 got.pix.polarity, got.last_flag);
                    end
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        if (fails < 10) begin
                            $display("Mismatch on event word %0d:", checked);
                            $display("  expected ts=%0d x=%0d y=%0d pol=%0b last=%0b",
                                     want.timestamp, want.pix.x_pos, want.pix.y_pos,
                                     want.pix.polarity, want.last_flag);
                            $display("  got      ts=%0d x=%0d y=%0d pol=%0b last=%0b",
                                     got.timestamp, got.pix.x_pos, got.pix.y_pos,
                                     got.pix.polarity, got.last_flag);
                        end
                        fails++;
                    end
                end
                checked++;
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: bench/tb.sv
// Top-level testbench: drives frames and register writes into the unpacker.
module tb;
    import ppeu_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES      = 100;
    localparam int SETTLE_CYCLES    = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte;
    logic                  i_frame_start;
    logic [FNUM_W-1:0]     i_frame_seq;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [TS_W-1:0]       o_timestamp;
    logic [COORD_W-1:0]    o_x_pos;
    logic [COORD_W-1:0]    o_y_pos;
    logic                  o_polarity;
    logic                  o_last_of_byte;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count    = 0;
    int setting_count = 0;
    bit quiet         = 1'b0;
    bit hold_req      = 1'b0;

    packed_pixel_event_unpacker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .i_frame_seq    (i_frame_seq),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_timestamp    (o_timestamp),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_polarity     (o_polarity),
        .o_last_of_byte (o_last_of_byte)
    );

    pixel_event_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .i_frame_seq     (i_frame_seq),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_timestamp     (o_timestamp),
        .i_x_pos         (o_x_pos),
        .i_y_pos         (o_y_pos),
        .i_polarity      (o_polarity),
        .i_last_of_byte  (o_last_of_byte),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d event words still outstanding.", pending_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, none while quiet, and one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall = !quiet && ($urandom_range(99) < 20);
            end
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_word(input logic [7:0] pix_byte, input logic start,
                             input logic [FNUM_W-1:0] fseq);
        if (!quiet && $urandom_range(99) < 20) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_data_byte   = pix_byte;
        i_frame_start = start;
        i_frame_seq   = fseq;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Bytes without events may still be in flight when the queue empties,
    // so the block is left to settle before its registers change.
    task automatic set_geometry(input int w, input int h, input int ivl);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_FRAME_WIDTH, APB_DATA_W'(w));
        apb_write(REG_FRAME_HEIGHT, APB_DATA_W'(h));
        apb_write(REG_INTERVAL, APB_DATA_W'(ivl));
        setting_count++;
    endtask

    task automatic run_phase(input int w, input int h, input int ivl, input int target);
        int                done_items;
        int                nb;
        int                r;
        int                len;
        logic [FNUM_W-1:0] fseq;
        set_geometry(w, h, ivl);
        done_items = 0;
        nb = (w * h + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
        if (nb == 0) begin
            nb = 1;
        end
        while (done_items < target) begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0:       fseq = '1;
                1:       fseq = '0;
                default: fseq = $urandom;
            endcase
            if (r < 70) begin
                // Whole frame, sometimes with trailing bytes past its end.
                len = nb + $urandom_range(2);
                for (int i = 0; i < len; i++) begin
                    send_word(8'($urandom), i == 0, fseq);
                end
            end else if (r < 85) begin
                len = (nb > 1) ? $urandom_range(nb - 1, 1) : 1;
                for (int i = 0; i < len; i++) begin
                    send_word(8'($urandom), i == 0, fseq);
                end
            end else begin
                len = 1 + $urandom_range(2);
                for (int i = 0; i < len; i++) begin
                    send_word(8'($urandom), 1'($urandom), FNUM_W'($urandom));
                end
            end
            done_items += len;
            if ($urandom_range(99) < 5) begin
                wait_results();
            end
        end
    endtask

    initial begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        i_frame_seq   = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry and interval.
        send_word(8'h55, 1'b1, 32'd3);
        send_word(8'hAA, 1'b0, 32'd3);

        // Width of one byte, two rows: a frame is two bytes, anything after is excess.
        set_geometry(4, 2, 1);
        send_word(8'h55, 1'b1, 32'd0);
        send_word(8'hAA, 1'b0, 32'd0);
        send_word(8'h69, 1'b0, 32'd0);
        send_word(8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_word(8'h1B, 1'b0, 32'hFFFF_FFFF);
        send_word(8'hE4, 1'b0, 32'hFFFF_FFFF);
        send_word(8'h00, 1'b1, 32'd5);
        send_word(8'h96, 1'b0, 32'd5);

        // Rows that split bytes, a padded last byte and the widest interval.
        set_geometry(5, 3, 20'hFFFFF);
        send_word(8'h99, 1'b1, 32'hFFFF_FFFF);
        send_word(8'h66, 1'b0, 32'hFFFF_FFFF);
        send_word(8'h5A, 1'b0, 32'd1);
        send_word(8'hA5, 1'b0, 32'd1);

        // Narrowing the width mid-frame: the old column is still reported once.
        set_geometry(8, 4, 7);
        send_word(8'h55, 1'b1, 32'd9);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_FRAME_WIDTH, 32'd4);
        send_word(8'h55, 1'b0, 32'd9);

        // Empty frames from a zero dimension.
        set_geometry(0, 3, 1);
        send_word(8'h55, 1'b1, 32'd2);
        set_geometry(6, 0, 1);
        send_word(8'hAA, 1'b1, 32'd2);

        // Dimensions above the cap, then the cap itself with a single row.
        set_geometry(4095, 4095, 1000);
        send_word(8'h55, 1'b1, 32'h8000_0000);
        send_word(8'hA6, 1'b0, 32'h8000_0000);
        send_word(8'h59, 1'b0, 32'h8000_0000);
        set_geometry(2048, 1, 3);
        send_word(8'h9A, 1'b1, 32'h7FFF_FFFF);
        send_word(8'h65, 1'b0, 32'h7FFF_FFFF);

        quiet = 1'b1;
        run_phase(4, 1, 1, 62);
        quiet = 1'b0;
        run_phase(5, 3, 20'hFFFFF, 62);

        // Long receiver hold-off while dense bytes keep coming, so the block backs up.
        set_geometry(16, 8, $urandom_range(20'hFFFFF, 1));
        hold_req = 1'b1;
        for (int i = 0; i < 14; i++) begin
            send_word((i % 2) ? 8'h99 : 8'h55, i == 0, 32'd77);
        end
        wait_results();

        run_phase(16, 8, $urandom_range(20'hFFFFF, 1), 62);
        run_phase(7, 2, $urandom_range(20'hFFFFF, 1), 62);
        run_phase($urandom_range(12, 4), $urandom_range(5, 1), $urandom_range(20'hFFFFF, 1), 62);
        run_phase($urandom_range(12, 4), $urandom_range(5, 1), $urandom_range(20'hFFFFF, 1), 62);

        wait_results();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d packed bytes over %0d register settings; checked %0d event words.",
                 sent_count, setting_count, checked_count);
        $display("Mismatches counted: %0d, words still outstanding: %0d.",
                 fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
